// File: hw/rtl/fhcf_pkg.sv
// Shared types and constants of the fan hysteresis and colour fade block.
`default_nettype none

package fhcf_pkg;

    localparam int TEMP_W    = 19;
    localparam int COLOR_W   = 29;
    localparam int TRIP_W    = 4;
    localparam int FADE_W    = 5;
    localparam int CFG_W     = 29;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W     = TEMP_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEPS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_HOT  = 3'd5;

    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST  = 19'sd65000;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST   = 19'sd40000;
    localparam logic [TRIP_W-1:0]        TRIP_COUNT_RST = 4'd3;
    localparam logic [FADE_W-1:0]        FADE_STEPS_RST = 5'd10;
    localparam logic [COLOR_W-1:0]       COLOR_COLD_RST = 29'h1000FF00;
    localparam logic [COLOR_W-1:0]       COLOR_HOT_RST  = 29'h10FF0000;
    localparam logic [TRIP_W-1:0]        HOT_COUNT_MAX  = 4'd15;

    typedef struct packed {
        logic load_sample;
        logic set_direct;
        logic div_start_ratio;
        logic div_start_step;
        logic take_quot;
        logic mix_step;
        logic mul;
        logic store_target;
        logic step_init;
        logic step_inc;
        logic emit;
        logic commit_held;
    } fhcf_cmd_t;

    typedef struct packed {
        logic ratio_direct;
        logic div_busy;
        logic div_done;
        logic n_zero;
        logic step_last;
        logic out_free;
    } fhcf_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/fan_hysteresis_color_fade.sv
// Top level of the thermostat fan controller with hysteresis and a fading status colour.
// With F = RATIO_FRAC_BITS and n fade steps, the ratio divide and each fade step use a
// serial divider giving an F + 1 bit quotient; each divide is followed by a multiply and add.
// The ratio divide is skipped when the ratio is clamped.
// The last output word of a sample may wait while the next sample is taken in.
// Reset clears the thermostat state and loads the default configuration at once.
`default_nettype none

module fan_hysteresis_color_fade
    import fhcf_pkg::*;
#(
    parameter int MAX_FADE_STEPS  = 16,
    parameter int RATIO_FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [TEMP_W-1:0] temperature,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     fan_on,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic [4:0]               brightness,
    output logic                     led_update,
    output logic                     last_step
);

    fhcf_cmd_t    cmd;
    fhcf_status_t status;

    fhcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fhcf_datapath #(
        .MAX_FADE_STEPS  (MAX_FADE_STEPS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .temperature (temperature),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .fan_on      (fan_on),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .brightness  (brightness),
        .led_update  (led_update),
        .last_step   (last_step)
    );

    // An accepted sample takes the controller out of idle, so in_ready is low in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    // A new output word is never loaded over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("output word overwritten");

    // The divider is only started when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start_ratio || cmd.div_start_step) |-> !status.div_busy)
        else $error("divider restarted while busy");

    // A loaded output word enters the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("output word lost");

endmodule

`default_nettype wire

// File: hw/rtl/fhcf_divider.sv
// Serial restoring divider giving floor(num * 2^(QW-1) / den) for num not above den.
`default_nettype none

module fhcf_divider
    import fhcf_pkg::*;
#(
    parameter int QW = 17
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  num,
    input  logic [DIV_W-1:0]  den,
    output logic              busy,
    output logic              done,
    output logic [QW-1:0]     quot
);

    localparam int CW = $clog2(QW + 1);

    logic [DIV_W:0]   rem_reg;
    logic [DIV_W:0]   rem_next;
    logic [DIV_W-1:0] den_reg;
    logic [QW-1:0]    quot_reg;
    logic [QW-1:0]    quot_next;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;
    logic [DIV_W:0]   base;

    always_comb
    begin
        ge        = rem_reg >= {1'b0, den_reg};
        base      = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next  = {base[DIV_W-1:0], 1'b0};
        quot_next = {quot_reg[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// File: hw/rtl/fhcf_datapath.sv
// Datapath: configuration registers, thermostat state, ratio divider, colour mixer and output word.
`default_nettype none

module fhcf_datapath
    import fhcf_pkg::*;
#(
    parameter int MAX_FADE_STEPS  = 16,
    parameter int RATIO_FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic signed [TEMP_W-1:0] temperature,
    input  fhcf_cmd_t                cmd,
    output fhcf_status_t             status,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic                     fan_on,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic [4:0]               brightness,
    output logic                     led_update,
    output logic                     last_step
);

    localparam int QW = RATIO_FRAC_BITS + 1;
    localparam int NW = $clog2(MAX_FADE_STEPS + 1);
    localparam int PW = QW + 10;
    localparam logic [QW-1:0] RATIO_ONE = QW'(1) << RATIO_FRAC_BITS;

    logic signed [TEMP_W-1:0] temp_high_reg;
    logic signed [TEMP_W-1:0] temp_low_reg;
    logic [TRIP_W-1:0]        trip_count_reg;
    logic [FADE_W-1:0]        fade_steps_reg;
    logic [COLOR_W-1:0]       color_cold_reg;
    logic [COLOR_W-1:0]       color_hot_reg;

    logic [TRIP_W-1:0]        hot_count_reg;
    logic [TRIP_W-1:0]        hot_count_next;
    logic                     fan_reg;
    logic                     fan_next;
    logic                     fan_mid;
    logic                     started_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [COLOR_W-1:0]       held_reg;
    logic [COLOR_W-1:0]       target_reg;
    logic [23:0]              prev_rgb_reg;
    logic [QW-1:0]            ratio_reg;
    logic [NW-1:0]            step_reg;
    logic [NW-1:0]            n_val;

    logic signed [PW-1:0]     prod_reg [4];
    logic signed [PW-1:0]     prod_next [4];
    logic signed [PW-1:0]     shifted [4];
    logic [7:0]               chan_a [4];
    logic [7:0]               chan_b [4];
    logic [7:0]               chan_mix [4];
    logic signed [8:0]        chan_diff;
    logic [COLOR_W-1:0]       from_c;
    logic [COLOR_W-1:0]       to_c;
    logic [COLOR_W-1:0]       mix_c;

    logic signed [TEMP_W:0]   num_s;
    logic signed [TEMP_W:0]   den_s;
    logic [DIV_W-1:0]         div_num;
    logic [DIV_W-1:0]         div_den;
    logic                     div_busy;
    logic                     div_done;
    logic [QW-1:0]            div_quot;

    logic                     out_valid_reg;
    logic                     fan_out_reg;
    logic [7:0]               red_reg;
    logic [7:0]               green_reg;
    logic [7:0]               blue_reg;
    logic [4:0]               brightness_reg;
    logic                     led_update_reg;
    logic                     last_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_high_reg  <= TEMP_HIGH_RST;
            temp_low_reg   <= TEMP_LOW_RST;
            trip_count_reg <= TRIP_COUNT_RST;
            fade_steps_reg <= FADE_STEPS_RST;
            color_cold_reg <= COLOR_COLD_RST;
            color_hot_reg  <= COLOR_HOT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEMP_HIGH:  temp_high_reg  <= cfg_data[TEMP_W-1:0];
                CFG_TEMP_LOW:   temp_low_reg   <= cfg_data[TEMP_W-1:0];
                CFG_TRIP_COUNT: trip_count_reg <= cfg_data[TRIP_W-1:0];
                CFG_FADE_STEPS: fade_steps_reg <= cfg_data[FADE_W-1:0];
                CFG_COLOR_COLD: color_cold_reg <= cfg_data[COLOR_W-1:0];
                CFG_COLOR_HOT:  color_hot_reg  <= cfg_data[COLOR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        hot_count_next = '0;
        fan_mid        = fan_reg;
        if ((temperature >= temp_high_reg) && !fan_reg)
        begin
            hot_count_next = (hot_count_reg == HOT_COUNT_MAX) ? hot_count_reg
                                                              : hot_count_reg + TRIP_W'(1);
            if (hot_count_next == trip_count_reg)
            begin
                fan_mid = 1'b1;
            end
        end
        fan_next = ((temperature <= temp_low_reg) && fan_mid) ? 1'b0 : fan_mid;
    end

    always_comb
    begin
        if (32'(fade_steps_reg) > 32'(MAX_FADE_STEPS))
        begin
            n_val = NW'(MAX_FADE_STEPS);
        end
        else
        begin
            n_val = NW'(fade_steps_reg);
        end
    end

    always_comb
    begin
        num_s = {temp_reg[TEMP_W-1], temp_reg} - {temp_low_reg[TEMP_W-1], temp_low_reg};
        den_s = {temp_high_reg[TEMP_W-1], temp_high_reg}
              - {temp_low_reg[TEMP_W-1], temp_low_reg};
        if (cmd.div_start_step)
        begin
            div_num = DIV_W'(step_reg);
            div_den = DIV_W'(n_val);
        end
        else
        begin
            div_num = num_s;
            div_den = den_s;
        end
    end

    fhcf_divider #(
        .QW (QW)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start_ratio | cmd.div_start_step),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        from_c = cmd.mix_step ? held_reg : color_cold_reg;
        to_c   = cmd.mix_step ? target_reg : color_hot_reg;
        chan_a[0] = from_c[7:0];
        chan_a[1] = from_c[15:8];
        chan_a[2] = from_c[23:16];
        chan_a[3] = {3'b000, from_c[28:24]};
        chan_b[0] = to_c[7:0];
        chan_b[1] = to_c[15:8];
        chan_b[2] = to_c[23:16];
        chan_b[3] = {3'b000, to_c[28:24]};
        for (int k = 0; k < 4; k++)
        begin
            chan_diff    = $signed({1'b0, chan_b[k]}) - $signed({1'b0, chan_a[k]});
            prod_next[k] = PW'(chan_diff) * PW'($signed({1'b0, ratio_reg}));
            shifted[k]   = prod_reg[k] >>> RATIO_FRAC_BITS;
            chan_mix[k]  = chan_a[k] + shifted[k][7:0];
        end
        mix_c = {chan_mix[3][4:0], chan_mix[2], chan_mix[1], chan_mix[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hot_count_reg <= '0;
            fan_reg       <= 1'b0;
            started_reg   <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_sample)
            begin
                hot_count_reg <= hot_count_next;
                fan_reg       <= fan_next;
                started_reg   <= 1'b1;
            end
            if (cmd.step_init)
            begin
                step_reg <= NW'(1);
            end
            else if (cmd.step_inc)
            begin
                step_reg <= step_reg + NW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            temp_reg <= temperature;
            if (!started_reg)
            begin
                held_reg     <= color_cold_reg;
                prev_rgb_reg <= color_cold_reg[23:0];
            end
            else
            begin
                prev_rgb_reg <= held_reg[23:0];
            end
        end
        if (cmd.set_direct)
        begin
            ratio_reg <= (temp_reg > temp_high_reg && !(temp_reg < temp_low_reg)) ? RATIO_ONE
                                                                                  : '0;
        end
        else if (cmd.take_quot)
        begin
            ratio_reg <= div_quot;
        end
        if (cmd.mul)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (cmd.store_target)
        begin
            target_reg <= mix_c;
        end
        if (cmd.commit_held)
        begin
            held_reg <= target_reg;
        end
        if (cmd.emit)
        begin
            fan_out_reg    <= fan_reg;
            red_reg        <= mix_c[23:16];
            green_reg      <= mix_c[15:8];
            blue_reg       <= mix_c[7:0];
            brightness_reg <= mix_c[28:24];
            led_update_reg <= mix_c[23:0] != prev_rgb_reg;
            last_step_reg  <= step_reg == n_val;
            prev_rgb_reg   <= mix_c[23:0];
        end
    end

    always_comb
    begin
        status.ratio_direct = (temp_reg < temp_low_reg) || (temp_reg > temp_high_reg)
                           || (temp_high_reg == temp_low_reg);
        status.div_busy     = div_busy;
        status.div_done     = div_done;
        status.n_zero       = n_val == '0;
        status.step_last    = step_reg == n_val;
        status.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign fan_on     = fan_out_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign brightness = brightness_reg;
    assign led_update = led_update_reg;
    assign last_step  = last_step_reg;

endmodule

`default_nettype wire

// File: hw/rtl/fhcf_ctrl.sv
// Controller state machine sequencing the ratio, the target colour and the fade steps.
`default_nettype none

module fhcf_ctrl
    import fhcf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  fhcf_status_t status,
    output fhcf_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RATIO = 4'd1;
    localparam logic [3:0] S_DIVR  = 4'd2;
    localparam logic [3:0] S_MULT  = 4'd3;
    localparam logic [3:0] S_ADDT  = 4'd4;
    localparam logic [3:0] S_STEP  = 4'd5;
    localparam logic [3:0] S_DIVS  = 4'd6;
    localparam logic [3:0] S_MULS  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = S_RATIO;
                end
            end
            S_RATIO:
            begin
                if (status.ratio_direct)
                begin
                    cmd.set_direct = 1'b1;
                    state_next     = S_MULT;
                end
                else
                begin
                    cmd.div_start_ratio = 1'b1;
                    state_next          = S_DIVR;
                end
            end
            S_DIVR:
            begin
                if (status.div_done)
                begin
                    cmd.take_quot = 1'b1;
                    state_next    = S_MULT;
                end
            end
            S_MULT:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADDT;
            end
            S_ADDT:
            begin
                cmd.store_target = 1'b1;
                cmd.step_init    = 1'b1;
                state_next       = S_STEP;
            end
            S_STEP:
            begin
                if (status.n_zero)
                begin
                    cmd.commit_held = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.div_start_step = 1'b1;
                    state_next         = S_DIVS;
                end
            end
            S_DIVS:
            begin
                if (status.div_done)
                begin
                    cmd.take_quot = 1'b1;
                    state_next    = S_MULS;
                end
            end
            S_MULS:
            begin
                cmd.mix_step = 1'b1;
                cmd.mul      = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.mix_step = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.step_last)
                    begin
                        cmd.commit_held = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.step_inc = 1'b1;
                        state_next   = S_STEP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: tb/fhcf_checker.sv
// Checker that predicts the fade words of the fan and colour fade block and compares them.
`timescale 1ns / 100ps

module fhcf_checker
    import fhcf_pkg::*;
#(
    parameter int MAX_FADE_STEPS  = 16,
    parameter int RATIO_FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic                     fan_on,
    input  logic [7:0]               red,
    input  logic [7:0]               green,
    input  logic [7:0]               blue,
    input  logic [4:0]               brightness,
    input  logic                     led_update,
    input  logic                     last_step,
    output int                       errors,
    output int                       outstanding
);

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic       fan;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [4:0] bright;
        logic       update;
        logic       last;
    } fade_word_t;

    localparam u64_t UNITY = u64_t'(1) << RATIO_FRAC_BITS;

    logic signed [TEMP_W-1:0] thr_high;
    logic signed [TEMP_W-1:0] thr_low;
    logic [TRIP_W-1:0]        trip_need;
    logic [FADE_W-1:0]        steps_cfg;
    logic [COLOR_W-1:0]       cold_color;
    logic [COLOR_W-1:0]       hot_color;
    logic [TRIP_W-1:0]        hot_run;
    logic                     fan_running;
    logic [COLOR_W-1:0]       held_color;
    logic                     seeded;
    int                       fail_count;
    fade_word_t               expected_words[$];

    function automatic int unsigned blend(int unsigned a, int unsigned b, u64_t r);
        longint acc;
        acc = longint'(a) * longint'(UNITY) + (longint'(b) - longint'(a)) * longint'(r);
        return 32'(acc >>> RATIO_FRAC_BITS);
    endfunction

    function automatic logic [COLOR_W-1:0] blend_color(logic [COLOR_W-1:0] from,
                                                       logic [COLOR_W-1:0] to, u64_t r);
        logic [COLOR_W-1:0] c;
        c[28:24] = 5'(blend(from[28:24], to[28:24], r));
        c[23:16] = 8'(blend(from[23:16], to[23:16], r));
        c[15:8]  = 8'(blend(from[15:8], to[15:8], r));
        c[7:0]   = 8'(blend(from[7:0], to[7:0], r));
        return c;
    endfunction

    function automatic u64_t temp_ratio(int lo, int hi, int t);
        if (t < lo)
            return 0;
        if (t > hi)
            return UNITY;
        if (hi == lo)
            return 0;
        return (u64_t'(t - lo) << RATIO_FRAC_BITS) / u64_t'(hi - lo);
    endfunction

    task automatic predict_fade(input logic signed [TEMP_W-1:0] reading);
        int                 t;
        int                 hi;
        int                 lo;
        int                 n;
        u64_t               r;
        u64_t               sr;
        logic [COLOR_W-1:0] target;
        logic [COLOR_W-1:0] c;
        logic [23:0]        prev_rgb;
        fade_word_t         w;
        t = reading;
        hi = thr_high;
        lo = thr_low;
        if (!seeded)
        begin
            held_color = cold_color;
            seeded = 1'b1;
        end
        if (t >= hi && !fan_running)
        begin
            if (hot_run < HOT_COUNT_MAX)
                hot_run = hot_run + 1'b1;
            if (hot_run == trip_need)
                fan_running = 1'b1;
        end
        else
        begin
            hot_run = '0;
        end
        if (t <= lo && fan_running)
            fan_running = 1'b0;
        r = temp_ratio(lo, hi, t);
        target = blend_color(cold_color, hot_color, r);
        n = (steps_cfg > MAX_FADE_STEPS) ? MAX_FADE_STEPS : steps_cfg;
        prev_rgb = held_color[23:0];
        for (int i = 1; i <= n; i++)
        begin
            sr = (u64_t'(i) << RATIO_FRAC_BITS) / u64_t'(n);
            c = blend_color(held_color, target, sr);
            w.fan    = fan_running;
            w.red    = c[23:16];
            w.green  = c[15:8];
            w.blue   = c[7:0];
            w.bright = c[28:24];
            w.update = (c[23:0] != prev_rgb);
            w.last   = (i == n);
            expected_words.push_back(w);
            prev_rgb = c[23:0];
        end
        held_color = target;
    endtask

    task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fade_word_t want;
        if (!rst_n)
        begin
            thr_high    = TEMP_HIGH_RST;
            thr_low     = TEMP_LOW_RST;
            trip_need   = TRIP_COUNT_RST;
            steps_cfg   = FADE_STEPS_RST;
            cold_color  = COLOR_COLD_RST;
            hot_color   = COLOR_HOT_RST;
            hot_run     = '0;
            fan_running = 1'b0;
            held_color  = '0;
            seeded      = 1'b0;
            fail_count  = 0;
            expected_words.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("fade word arrived with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("fan_on", want.fan, fan_on);
                    check_field("red", want.red, red);
                    check_field("green", want.green, green);
                    check_field("blue", want.blue, blue);
                    check_field("brightness", want.bright, brightness);
                    check_field("led_update", want.update, led_update);
                    check_field("last_step", want.last, last_step);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TEMP_HIGH:  thr_high   = cfg_data[TEMP_W-1:0];
                    CFG_TEMP_LOW:   thr_low    = cfg_data[TEMP_W-1:0];
                    CFG_TRIP_COUNT: trip_need  = cfg_data[TRIP_W-1:0];
                    CFG_FADE_STEPS: steps_cfg  = cfg_data[FADE_W-1:0];
                    CFG_COLOR_COLD: cold_color = cfg_data[COLOR_W-1:0];
                    CFG_COLOR_HOT:  hot_color  = cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_fade(temperature);
            errors      <= fail_count;
            outstanding <= expected_words.size();
        end
    end

endmodule

// File: tb/fan_hysteresis_color_fade_tb.sv
// Testbench top of the fan hysteresis and colour fade block: stimulus, idling and verdict.
`timescale 1ns / 100ps

module fan_hysteresis_color_fade_tb;
    import fhcf_pkg::*;

    localparam int MAX_FADE_STEPS  = 16;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int DRAIN           = (RATIO_FRAC_BITS + 5) * (MAX_FADE_STEPS + 1) + 50;
    localparam int LONG_HOLD       = 600;
    localparam int RAND_PHASES     = 8;
    localparam int PHASE_WORDS     = 50;
    localparam int COLOR_ALL       = 29'h1FFFFFFF;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [TEMP_W-1:0] temperature;
    logic                     out_valid;
    logic                     out_ready;
    logic                     fan_on;
    logic [7:0]               red;
    logic [7:0]               green;
    logic [7:0]               blue;
    logic [4:0]               brightness;
    logic                     led_update;
    logic                     last_step;
    int                       errors;
    int                       outstanding;
    logic                     tx_gaps;
    logic                     rx_gaps;
    int                       hold_req;
    int                       hold_seen;
    int                       hold_left;

    fan_hysteresis_color_fade #(
        .MAX_FADE_STEPS  (MAX_FADE_STEPS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .temperature (temperature),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fan_on      (fan_on),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .brightness  (brightness),
        .led_update  (led_update),
        .last_step   (last_step)
    );

    fhcf_checker #(
        .MAX_FADE_STEPS  (MAX_FADE_STEPS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .temperature (temperature),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fan_on      (fan_on),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .brightness  (brightness),
        .led_update  (led_update),
        .last_step   (last_step),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;

    always #4 clk = ~clk;

    // A new hold request starts a long stretch in which no fade word is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_seen <= 0;
            hold_left <= 0;
            out_ready <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !rx_gaps || ($urandom_range(99) >= 18);
        end
    end

    initial
    begin
        #8_000_000;
        $display("[fan_hysteresis_color_fade] ERROR");
        $finish;
    end

    function automatic int rand_between(int a, int b);
        if (a > b)
            return b + int'($urandom_range(a - b));
        return a + int'($urandom_range(b - a));
    endfunction

    task automatic send(input int t);
        if (tx_gaps)
        begin
            while ($urandom_range(99) < 18)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        temperature <= TEMP_W'(t);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic put(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
    endtask

    task automatic configure(input int th, input int tl, input int trip, input int fade,
                             input int cold, input int hot);
        put(CFG_TEMP_HIGH, th);
        put(CFG_TEMP_LOW, tl);
        put(CFG_TRIP_COUNT, trip);
        put(CFG_FADE_STEPS, fade);
        put(CFG_COLOR_COLD, cold);
        put(CFG_COLOR_HOT, hot);
        cfg_we <= 1'b0;
    endtask

    task automatic quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    initial
    begin
        int warm_up[9];
        int th;
        int tl;
        int tmp;
        int trip;
        int fade;
        int pick;
        int sent;
        int kind;
        int len;
        warm_up     = '{30000, 65000, 65000, 65000, 150000, 52500, 40000, -262144, 262143};
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        temperature = '0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        hold_req    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (warm_up[k])
            send(warm_up[k]);
        quiet();
        configure(1000, -1000, 1, 1, 0, COLOR_ALL);
        send(1000);
        send(0);
        send(-1000);
        quiet();
        configure(0, 0, 0, 0, COLOR_HOT_RST, COLOR_COLD_RST);
        send(0);
        send(5);
        quiet();
        configure(-40000, 150000, 2, 31, COLOR_ALL, 0);
        send(150000);
        send(150000);
        send(0);
        quiet();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            th = rand_between(-40000, 150000);
            tl = rand_between(-40000, 150000);
            if (tl > th)
            begin
                tmp = th;
                th = tl;
                tl = tmp;
            end
            pick = $urandom_range(9);
            if (pick == 0)
                tl = th;
            else if (pick == 1)
            begin
                tmp = th;
                th = tl;
                tl = tmp;
            end
            trip = (ph == 0) ? 0 : (ph == 1) ? 15 : $urandom_range(1, 5);
            pick = $urandom_range(19);
            if (pick < 12)
                fade = $urandom_range(1, 3);
            else if (pick < 15)
                fade = $urandom_range(4, 8);
            else if (pick < 17)
                fade = 16;
            else if (pick == 17)
                fade = 0;
            else
                fade = $urandom_range(17, 31);
            if (ph == 1)
                fade = 2;
            else if (ph == 2)
                fade = 16;
            configure(th, tl, trip, fade, $urandom() & COLOR_ALL, $urandom() & COLOR_ALL);

            tx_gaps = (ph != 1) && (ph != 3);
            rx_gaps <= (ph != 3);
            if (ph == 1)
                hold_req <= hold_req + 1;

            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                kind = $urandom_range(9);
                if (kind < 4)
                begin
                    len = (trip == 0) ? $urandom_range(14, 20) : trip + $urandom_range(0, 2);
                    repeat (len) send(rand_between(th, th + 20000));
                    sent += len;
                end
                else if (kind < 6)
                begin
                    len = $urandom_range(1, 3);
                    repeat (len) send(rand_between(tl - 20000, tl));
                    sent += len;
                end
                else if (kind < 8)
                begin
                    send(rand_between(tl, th));
                    sent++;
                end
                else if (kind == 8)
                begin
                    send(rand_between(-40000, 150000));
                    sent++;
                end
                else
                begin
                    send($urandom());
                    sent++;
                end
            end
            quiet();
        end

        if (errors == 0)
            $display("[fan_hysteresis_color_fade] OK");
        else
            $display("[fan_hysteresis_color_fade] ERROR");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/fhcf_pkg.sv
hw/rtl/fhcf_divider.sv
hw/rtl/fhcf_datapath.sv
hw/rtl/fhcf_ctrl.sv
hw/rtl/fan_hysteresis_color_fade.sv
tb/fhcf_checker.sv
tb/fan_hysteresis_color_fade_tb.sv
